// ----- design/assert_macros.svh -----
// assertion helpers used by the checker file pptd_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked during reset
`define CHK_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");

// next-cycle implication, masked during reset
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");

// next-cycle implication, live during reset
`define CHK_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("check failed");

`endif

// ----- design/pptd_pkg.sv -----
package pptd_pkg;

   localparam int CAPTURE_WIDTH = 16;
   localparam int GAIN_W        = 16;
   localparam int ON_TIME_W     = 32;
   localparam int SPEED_W       = 16;
   localparam int LIMIT_W       = 8;
   localparam int COUNT_W       = LIMIT_W + 1;
   localparam int SPEED_SHIFT   = 16;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int PRODUCT_W     = CAPTURE_WIDTH + GAIN_W;
   localparam int CMP_W         = (PRODUCT_W > ON_TIME_W) ? PRODUCT_W : ON_TIME_W;

   localparam logic OP_EDGE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [GAIN_W-1:0]    CYCLE_GAIN_RST  = GAIN_W'(1);
   localparam logic [ON_TIME_W-1:0] MIN_ON_RST      = '0;
   localparam logic [ON_TIME_W-1:0] MAX_ON_RST      = '1;
   localparam logic [SPEED_W-1:0]   SPEED_LIMIT_RST = '1;
   localparam logic [LIMIT_W-1:0]   STOP_LIMIT_RST  = LIMIT_W'(10);
   localparam logic [LIMIT_W-1:0]   START_LIMIT_RST = LIMIT_W'(10);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CYCLE_GAIN  = 3'd0,
      CSR_MIN_ON      = 3'd1,
      CSR_MAX_ON      = 3'd2,
      CSR_SPEED_LIMIT = 3'd3,
      CSR_STOP_LIMIT  = 3'd4,
      CSR_START_LIMIT = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0]    cycle_gain;
      logic [ON_TIME_W-1:0] min_on_time;
      logic [ON_TIME_W-1:0] max_on_time;
      logic [SPEED_W-1:0]   speed_limit;
      logic [LIMIT_W-1:0]   stop_count_limit;
      logic [LIMIT_W-1:0]   start_count_limit;
   } cfg_type;

   typedef struct packed {
      logic                     operation;
      logic [CAPTURE_WIDTH-1:0] capture_value;
      logic                     motor_stopped;
   } evt_type;

   typedef struct packed {
      logic                     expect_falling;
      logic [CAPTURE_WIDTH-1:0] rise_time;
      logic [COUNT_W-1:0]       short_pulse_count;
      logic [COUNT_W-1:0]       valid_pulse_count;
      logic [COUNT_W-1:0]       idle_tick_count;
   } state_type;

   typedef struct packed {
      logic [SPEED_W-1:0] speed_command;
      logic               speed_valid;
      logic               start_request;
      logic               stop_request;
      logic               capture_error;
   } result_type;

endpackage

// ----- design/pptd_req_if.sv -----
interface pptd_req_if import pptd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     operation;
   logic [CAPTURE_WIDTH-1:0] capture_value;
   logic                     motor_stopped;

   modport source (output valid, operation, capture_value, motor_stopped, input ready);
   modport sink   (input valid, operation, capture_value, motor_stopped, output ready);
endinterface

// ----- design/pptd_rsp_if.sv -----
interface pptd_rsp_if import pptd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [SPEED_W-1:0] speed_command;
   logic               speed_valid;
   logic               start_request;
   logic               stop_request;
   logic               capture_error;

   modport source (output valid, speed_command, speed_valid, start_request, stop_request,
                   capture_error, input ready);
   modport sink   (input valid, speed_command, speed_valid, start_request, stop_request,
                   capture_error, output ready);
endinterface

// ----- design/pptd_csr_if.sv -----
interface pptd_csr_if import pptd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/pwm_pulse_throttle_decoder_unit.sv -----
// Path: a beat accepted on req is registered in the event register, then decoded and
//   registered in the result register, and shown on rsp, once the result register is free.
// Throughput: one beat per cycle while rsp is not stalled, set by a 16-bit subtract,
//   a 16x16 multiply, a 32-bit subtract and compares between event and result register.
// Reset (synchronous, active high): configuration registers to their defaults,
//   decoder state and both valid flags cleared.
module pwm_pulse_throttle_decoder_unit import pptd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   pptd_req_if.sink    req_bus,
   pptd_rsp_if.source  rsp_bus,
   pptd_csr_if.sink    csr_bus
);

   cfg_type    cfg_ff,       cfg_in;
   state_type  state_ff,     state_in;
   evt_type    evt_ff,       evt_in;
   logic       evt_valid_ff, evt_valid_in;
   result_type rsp_ff,       rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;

   state_type  state_next;
   result_type result;
   logic       out_free;
   logic       advance;
   logic       req_take;

   pptd_eval u_eval (
      .evt        (evt_ff),
      .state      (state_ff),
      .cfg        (cfg_ff),
      .state_next (state_next),
      .result     (result)
   );

   assign out_free          = !rsp_valid_ff || rsp_bus.ready;
   assign advance           = evt_valid_ff && out_free;
   assign req_bus.ready     = !evt_valid_ff || out_free;
   assign req_take          = req_bus.valid && req_bus.ready;
   assign csr_bus.ready     = 1'b1;

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.speed_command = rsp_ff.speed_command;
   assign rsp_bus.speed_valid   = rsp_ff.speed_valid;
   assign rsp_bus.start_request = rsp_ff.start_request;
   assign rsp_bus.stop_request  = rsp_ff.stop_request;
   assign rsp_bus.capture_error = rsp_ff.capture_error;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid && csr_bus.ready) begin
         unique case (csr_bus.index)
            CSR_CYCLE_GAIN:  cfg_in.cycle_gain        = csr_bus.data[GAIN_W-1:0];
            CSR_MIN_ON:      cfg_in.min_on_time       = csr_bus.data[ON_TIME_W-1:0];
            CSR_MAX_ON:      cfg_in.max_on_time       = csr_bus.data[ON_TIME_W-1:0];
            CSR_SPEED_LIMIT: cfg_in.speed_limit       = csr_bus.data[SPEED_W-1:0];
            CSR_STOP_LIMIT:  cfg_in.stop_count_limit  = csr_bus.data[LIMIT_W-1:0];
            CSR_START_LIMIT: cfg_in.start_count_limit = csr_bus.data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = advance ? state_next : state_ff;
      rsp_in       = advance ? result : rsp_ff;
      rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && !rsp_bus.ready);
      evt_valid_in = req_take ? 1'b1 : (evt_valid_ff && !advance);
      evt_in       = evt_ff;
      if (req_take) begin
         evt_in.operation     = req_bus.operation;
         evt_in.capture_value = req_bus.capture_value;
         evt_in.motor_stopped = req_bus.motor_stopped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cycle_gain        <= CYCLE_GAIN_RST;
         cfg_ff.min_on_time       <= MIN_ON_RST;
         cfg_ff.max_on_time       <= MAX_ON_RST;
         cfg_ff.speed_limit       <= SPEED_LIMIT_RST;
         cfg_ff.stop_count_limit  <= STOP_LIMIT_RST;
         cfg_ff.start_count_limit <= START_LIMIT_RST;
         state_ff                 <= '0;
         evt_valid_ff             <= 1'b0;
         rsp_valid_ff             <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         evt_valid_ff <= evt_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      evt_ff <= evt_in;
      rsp_ff <= rsp_in;
   end

endmodule

// ----- design/pptd_eval.sv -----
module pptd_eval import pptd_pkg::*; (
   input  evt_type    evt,
   input  state_type  state,
   input  cfg_type    cfg,
   output state_type  state_next,
   output result_type result
);

   logic [CAPTURE_WIDTH-1:0] width;
   logic [PRODUCT_W-1:0]     on_time;
   logic [CMP_W-1:0]         on_ext;
   logic [CMP_W-1:0]         min_ext;
   logic [CMP_W-1:0]         max_ext;
   logic [CMP_W-1:0]         over;
   logic [CMP_W-1:0]         scaled;
   logic                     below_min;
   logic                     above_max;
   logic                     speed_ok;
   logic [COUNT_W-1:0]       stop_lim;
   logic [COUNT_W-1:0]       start_lim;

   assign width     = evt.capture_value - state.rise_time;
   assign on_time   = PRODUCT_W'(width) * PRODUCT_W'(cfg.cycle_gain);
   assign on_ext    = CMP_W'(on_time);
   assign min_ext   = CMP_W'(cfg.min_on_time);
   assign max_ext   = CMP_W'(cfg.max_on_time);
   assign below_min = on_ext < min_ext;
   assign above_max = on_ext > max_ext;
   assign over      = on_ext - min_ext;
   assign scaled    = over >> SPEED_SHIFT;
   assign speed_ok  = scaled <= CMP_W'(cfg.speed_limit);
   assign stop_lim  = COUNT_W'(cfg.stop_count_limit);
   assign start_lim = COUNT_W'(cfg.start_count_limit);

   always_comb begin
      state_next = state;
      result     = '0;
      if (evt.operation == OP_TICK) begin
         if (!evt.motor_stopped) begin
            if (state.idle_tick_count > stop_lim) begin
               result.stop_request = 1'b1;
            end else begin
               state_next.idle_tick_count = state.idle_tick_count + COUNT_W'(1);
            end
         end
      end else if (!state.expect_falling) begin
         state_next.rise_time       = evt.capture_value;
         state_next.idle_tick_count = '0;
         state_next.expect_falling  = 1'b1;
      end else begin
         state_next.expect_falling = 1'b0;
         if (width == '0) begin
            result.capture_error = 1'b1;
         end else if (!evt.motor_stopped) begin
            if (below_min) begin
               if (state.short_pulse_count > stop_lim) begin
                  result.stop_request = 1'b1;
               end else begin
                  state_next.short_pulse_count = state.short_pulse_count + COUNT_W'(1);
               end
            end else begin
               if (speed_ok) begin
                  result.speed_command = scaled[SPEED_W-1:0];
                  result.speed_valid   = 1'b1;
               end
               state_next.short_pulse_count = '0;
            end
            state_next.valid_pulse_count = '0;
         end else begin
            if (!below_min && !above_max) begin
               if (state.valid_pulse_count > start_lim) begin
                  result.start_request = 1'b1;
               end else begin
                  state_next.valid_pulse_count = state.valid_pulse_count + COUNT_W'(1);
               end
            end else begin
               state_next.valid_pulse_count = '0;
            end
            state_next.short_pulse_count = '0;
         end
      end
   end

endmodule

// ----- design/pptd_checker.sv -----
`include "assert_macros.svh"

module pptd_checker import pptd_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [SPEED_W-1:0] speed_command,
   input logic               speed_valid,
   input logic               start_request,
   input logic               stop_request,
   input logic               capture_error
);

   logic [SPEED_W+3:0] rsp_payload;

   assign rsp_payload = {speed_command, speed_valid, start_request, stop_request, capture_error};

   `CHK_NEXT_ALWAYS(a_reset_clears_rsp, clock, reset, !rsp_valid)

   `CHK_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   `CHK_SAME(a_speed_alone, clock, reset, rsp_valid && speed_valid, !start_request && !stop_request && !capture_error)

   `CHK_SAME(a_error_alone, clock, reset, rsp_valid && capture_error, !start_request && !stop_request && !speed_valid)

   `CHK_SAME(a_idle_command, clock, reset, rsp_valid && !speed_valid, speed_command == '0)

endmodule

bind pwm_pulse_throttle_decoder_unit pptd_checker u_pptd_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .speed_command (rsp_bus.speed_command),
   .speed_valid   (rsp_bus.speed_valid),
   .start_request (rsp_bus.start_request),
   .stop_request  (rsp_bus.stop_request),
   .capture_error (rsp_bus.capture_error)
);
